@@ rtl/rbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants of the ray/box slab intersection pipeline.
// ----------------------------------------------------------------------------
package rbs_pkg;

	localparam int VALUE_BITS    = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int AXES          = 3;
	localparam int CFG_IDX_BITS  = 3;
	// lane latency from the input register to the ordered slab distances
	localparam int LANE_LAT      = VALUE_BITS + 4;

	typedef logic signed [VALUE_BITS-1:0] value_t;

	localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		value_t origin_x;
		value_t origin_y;
		value_t origin_z;
		value_t dir_x;
		value_t dir_y;
		value_t dir_z;
		value_t t_start;
		value_t t_end;
	} ray_in_t;

	typedef struct packed {
		logic   hit;
		value_t t_enter;
		value_t t_exit;
	} ray_out_t;

	typedef struct packed {
		value_t t_near;
		value_t t_far;
		logic   zero;
		logic   in_slab;
	} slab_t;

endpackage
`default_nettype wire

@@ rtl/rbs_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_div
// Pipelined restoring divider: num / den scaled by 2^FRAC_BITS, truncated,
// saturated to the signed value range. One quotient bit per stage.
// ----------------------------------------------------------------------------
module rbs_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire                                clk,
	input  wire                                en,
	input  wire  [rbs_pkg::VALUE_BITS:0]       num_mag,
	input  wire  [rbs_pkg::VALUE_BITS-1:0]     den_mag,
	input  wire                                neg,
	output rbs_pkg::value_t                    quot
);
	import rbs_pkg::*;

	localparam int VB = VALUE_BITS;
	localparam int NW = VB + 1 + FRAC_BITS;
	localparam int CW = (NW > 2 * VB) ? NW : 2 * VB;

	logic [CW-1:0] rem_p [0:VB];
	logic [VB-1:0] q_p   [0:VB];
	logic [VB-1:0] den_p [0:VB];
	logic          neg_p [0:VB];
	logic          ovf_p [0:VB];

	logic [CW-1:0] num_ext;
	logic [VB-1:0] lim;
	logic          sat;
	logic [VB-1:0] q_sat;

	assign num_ext = CW'(num_mag) << FRAC_BITS;
	assign lim     = neg_p[VB] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
	assign sat     = ovf_p[VB] || (q_p[VB] > lim);
	assign q_sat   = sat ? lim : q_p[VB];

	always_ff @(posedge clk) begin
		if (en) begin
			// a quotient of more than VB bits saturates in any case
			rem_p[0] <= num_ext;
			q_p[0]   <= '0;
			den_p[0] <= den_mag;
			neg_p[0] <= neg;
			ovf_p[0] <= num_ext >= (CW'(den_mag) << VB);
			for (int s = 1; s <= VB; s++) begin
				den_p[s] <= den_p[s-1];
				neg_p[s] <= neg_p[s-1];
				ovf_p[s] <= ovf_p[s-1];
				if (rem_p[s-1] >= (CW'(den_p[s-1]) << (VB - s))) begin
					rem_p[s] <= rem_p[s-1] - (CW'(den_p[s-1]) << (VB - s));
					q_p[s]   <= q_p[s-1] | (VB'(1) << (VB - s));
				end else begin
					rem_p[s] <= rem_p[s-1];
					q_p[s]   <= q_p[s-1];
				end
			end
			quot <= neg_p[VB] ? value_t'(-q_sat) : value_t'(q_sat);
		end
	end

endmodule
`default_nettype wire

@@ rtl/rbs_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_lane
// One axis: slab offsets, two dividers, and ordering of the two distances.
// ----------------------------------------------------------------------------
module rbs_lane #(
	parameter int FRAC_BITS = 16
) (
	input  wire                 clk,
	input  wire                 en,
	input  rbs_pkg::value_t     origin,
	input  rbs_pkg::value_t     dir,
	input  rbs_pkg::value_t     bmin,
	input  rbs_pkg::value_t     bmax,
	output rbs_pkg::slab_t      slab
);
	import rbs_pkg::*;

	localparam int VB = VALUE_BITS;
	localparam int DL = VB + 2;

	logic signed [VB:0] off_min;
	logic signed [VB:0] off_max;

	logic [VB:0]   mag_min_s2;
	logic [VB:0]   mag_max_s2;
	logic [VB-1:0] den_s2;
	logic          neg_min_s2;
	logic          neg_max_s2;
	logic          zero_s2;
	logic          inside_s2;

	logic zero_p   [0:DL-1];
	logic inside_p [0:DL-1];

	value_t t_a;
	value_t t_b;

	assign off_min = {bmin[VB-1], bmin} - {origin[VB-1], origin};
	assign off_max = {bmax[VB-1], bmax} - {origin[VB-1], origin};

	always_ff @(posedge clk) begin
		if (en) begin
			mag_min_s2 <= off_min[VB] ? (VB+1)'(-off_min) : (VB+1)'(off_min);
			mag_max_s2 <= off_max[VB] ? (VB+1)'(-off_max) : (VB+1)'(off_max);
			den_s2     <= dir[VB-1] ? VB'(-dir) : VB'(dir);
			neg_min_s2 <= off_min[VB] ^ dir[VB-1];
			neg_max_s2 <= off_max[VB] ^ dir[VB-1];
			zero_s2    <= (dir == '0);
			inside_s2  <= (origin >= bmin) && (origin <= bmax);

			zero_p[0]   <= zero_s2;
			inside_p[0] <= inside_s2;
			for (int i = 1; i < DL; i++) begin
				zero_p[i]   <= zero_p[i-1];
				inside_p[i] <= inside_p[i-1];
			end

			// order the two distances
			slab.t_near  <= (t_a > t_b) ? t_b : t_a;
			slab.t_far   <= (t_a > t_b) ? t_a : t_b;
			slab.zero    <= zero_p[DL-1];
			slab.in_slab <= inside_p[DL-1];
		end
	end

	rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_min (
		.clk     (clk),
		.en      (en),
		.num_mag (mag_min_s2),
		.den_mag (den_s2),
		.neg     (neg_min_s2),
		.quot    (t_a)
	);

	rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_max (
		.clk     (clk),
		.en      (en),
		.num_mag (mag_max_s2),
		.den_mag (den_s2),
		.neg     (neg_max_s2),
		.quot    (t_b)
	);

endmodule
`default_nettype wire

@@ rtl/rbs_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_merge
// Combine the three slabs with the ray interval into hit and narrowed span.
// ----------------------------------------------------------------------------
module rbs_merge (
	input  wire                 clk,
	input  wire                 en,
	input  rbs_pkg::slab_t      slab_x,
	input  rbs_pkg::slab_t      slab_y,
	input  rbs_pkg::slab_t      slab_z,
	input  rbs_pkg::value_t     t_start,
	input  rbs_pkg::value_t     t_end,
	output rbs_pkg::ray_out_t   result
);
	import rbs_pkg::*;

	value_t n_x, n_y, n_z, f_x, f_y, f_z;
	value_t n_a, n_b, f_a, f_b;
	value_t tmin_s1, tmax_s1;
	logic   miss_s1;

	// a zero-direction axis sets no limit
	assign n_x = slab_x.zero ? VALUE_MIN : slab_x.t_near;
	assign n_y = slab_y.zero ? VALUE_MIN : slab_y.t_near;
	assign n_z = slab_z.zero ? VALUE_MIN : slab_z.t_near;
	assign f_x = slab_x.zero ? VALUE_MAX : slab_x.t_far;
	assign f_y = slab_y.zero ? VALUE_MAX : slab_y.t_far;
	assign f_z = slab_z.zero ? VALUE_MAX : slab_z.t_far;

	assign n_a = (n_x > t_start) ? n_x : t_start;
	assign n_b = (n_y > n_z) ? n_y : n_z;
	assign f_a = (f_x < t_end) ? f_x : t_end;
	assign f_b = (f_y < f_z) ? f_y : f_z;

	always_ff @(posedge clk) begin
		if (en) begin
			tmin_s1 <= (n_a > n_b) ? n_a : n_b;
			tmax_s1 <= (f_a < f_b) ? f_a : f_b;
			miss_s1 <= (slab_x.zero && !slab_x.in_slab) ||
				(slab_y.zero && !slab_y.in_slab) ||
				(slab_z.zero && !slab_z.in_slab);

			if (!miss_s1 && (tmin_s1 <= tmax_s1)) begin
				result.hit     <= 1'b1;
				result.t_enter <= tmin_s1;
				result.t_exit  <= tmax_s1;
			end else begin
				result.hit     <= 1'b0;
				result.t_enter <= '0;
				result.t_exit  <= '0;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/ray_box_slab_intersect.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Fixed-point ray versus axis-aligned box slab test, one lane per axis.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+-------------------------
//   in      | in  | in_valid / in_stall     | in_data   (ray_in_t)
//   out     | out | out_valid / out_stall   | out_data  (ray_out_t)
//   cfg     | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item per cycle while no stall holds the pipeline; the latency is set by
// the one-bit-per-stage divider pipeline in each lane.
// Reset clears valid bits and the box corners to zero.
// An output register plus one skid entry absorb output stalls; in_stall
// rises only when the skid entry is occupied, and then the pipeline holds.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect #(
	parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  rbs_pkg::ray_in_t                    in_data,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output rbs_pkg::ray_out_t                   out_data,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [rbs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  rbs_pkg::value_t                     cfg_data
);
	import rbs_pkg::*;

	localparam int DEPTH = LANE_LAT + 3;

	value_t   box_min_q [0:AXES-1];
	value_t   box_max_q [0:AXES-1];
	ray_in_t  ray_s1;
	value_t   ts_q [0:LANE_LAT-1];
	value_t   te_q [0:LANE_LAT-1];
	logic     vld_q [0:DEPTH-1];
	logic     en;
	slab_t    slab_x, slab_y, slab_z;
	ray_out_t merged;
	ray_out_t skid_q;
	logic     skid_valid_q;
	logic     take;

	assign en        = !skid_valid_q;
	assign in_stall  = skid_valid_q;
	assign cfg_ready = 1'b1;
	assign take      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				box_min_q[i] <= '0;
				box_max_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BOX_MIN_X: box_min_q[0] <= cfg_data;
				REG_BOX_MIN_Y: box_min_q[1] <= cfg_data;
				REG_BOX_MIN_Z: box_min_q[2] <= cfg_data;
				REG_BOX_MAX_X: box_max_q[0] <= cfg_data;
				REG_BOX_MAX_Y: box_max_q[1] <= cfg_data;
				REG_BOX_MAX_Z: box_max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= in_data;
			ts_q[0] <= ray_s1.t_start;
			te_q[0] <= ray_s1.t_end;
			for (int i = 1; i < LANE_LAT; i++) begin
				ts_q[i] <= ts_q[i-1];
				te_q[i] <= te_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < DEPTH; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	rbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
		.clk(clk), .en(en), .origin(ray_s1.origin_x), .dir(ray_s1.dir_x),
		.bmin(box_min_q[0]), .bmax(box_max_q[0]), .slab(slab_x)
	);

	rbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
		.clk(clk), .en(en), .origin(ray_s1.origin_y), .dir(ray_s1.dir_y),
		.bmin(box_min_q[1]), .bmax(box_max_q[1]), .slab(slab_y)
	);

	rbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
		.clk(clk), .en(en), .origin(ray_s1.origin_z), .dir(ray_s1.dir_z),
		.bmin(box_min_q[2]), .bmax(box_max_q[2]), .slab(slab_z)
	);

	rbs_merge u_merge (
		.clk     (clk),
		.en      (en),
		.slab_x  (slab_x),
		.slab_y  (slab_y),
		.slab_z  (slab_z),
		.t_start (ts_q[LANE_LAT-1]),
		.t_end   (te_q[LANE_LAT-1]),
		.result  (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take || !out_valid) begin
			if (skid_valid_q) begin
				out_valid    <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid <= vld_q[DEPTH-1];
			end
		end else if (vld_q[DEPTH-1] && en) begin
			// output blocked: park the item
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_valid) begin
			out_data <= skid_valid_q ? skid_q : merged;
		end else if (vld_q[DEPTH-1] && en) begin
			skid_q <= merged;
		end
	end

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid)
		else $error("skid entry held without an output item");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.t_enter == '0 && out_data.t_exit == '0)
		else $error("miss carries a nonzero interval");

	a_hit_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.t_enter <= out_data.t_exit)
		else $error("hit with an empty interval");
`endif

endmodule
`default_nettype wire

@@ dv/slab_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_checker
// Watches the ray, result and box-register channels of the slab intersection
// block, predicts the hit flag and narrowed interval of every accepted ray,
// and compares each accepted result in order against the prediction.
// ----------------------------------------------------------------------------
module slab_checker (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	input  wire                               in_stall,
	input  rbs_pkg::ray_in_t                  in_data,
	input  wire                               out_valid,
	input  wire                               out_stall,
	input  rbs_pkg::ray_out_t                 out_data,
	input  wire                               cfg_valid,
	input  wire                               cfg_ready,
	input  wire [rbs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  rbs_pkg::value_t                   cfg_data,
	output int                                errors,
	output int                                pending
);
	import rbs_pkg::*;

	value_t   box_lo [AXES];
	value_t   box_hi [AXES];
	ray_out_t hit_queue [$];

	// scaled quotient, truncated toward zero, saturated; den is nonzero
	function automatic longint slab_div(longint num, longint den);
		bit neg;
		bit sat;
		longint unsigned n, d, lim, q, r;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
		q = n / d;
		r = n % d;
		sat = q > lim;
		for (int i = 0; i < FRAC_BITS_DEF && !sat; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 1;
			end
			if (q > lim)
				sat = 1;
		end
		if (sat)
			q = lim;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic ray_out_t slab_test(ray_in_t ray);
		value_t   org [AXES];
		value_t   dv [AXES];
		longint   tmin, tmax, tn, tf, tsw;
		bit       hit;
		ray_out_t res;
		org = '{ray.origin_x, ray.origin_y, ray.origin_z};
		dv  = '{ray.dir_x, ray.dir_y, ray.dir_z};
		tmin = ray.t_start;
		tmax = ray.t_end;
		hit = 1;
		for (int a = 0; a < AXES; a++) begin
			if (dv[a] == 0) begin
				if (org[a] < box_lo[a] || org[a] > box_hi[a]) begin
					hit = 0;
					break;
				end
			end else begin
				tn = slab_div(longint'(box_lo[a]) - longint'(org[a]), dv[a]);
				tf = slab_div(longint'(box_hi[a]) - longint'(org[a]), dv[a]);
				if (tn > tf) begin
					tsw = tn;
					tn = tf;
					tf = tsw;
				end
				if (tn > tmin)
					tmin = tn;
				if (tf < tmax)
					tmax = tf;
			end
			if (tmin > tmax) begin
				hit = 0;
				break;
			end
		end
		res.hit = hit;
		res.t_enter = hit ? value_t'(tmin) : '0;
		res.t_exit  = hit ? value_t'(tmax) : '0;
		return res;
	endfunction

	task automatic report(string field, longint want, longint got);
		$display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		ray_out_t want;
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				box_lo[a] = '0;
				box_hi[a] = '0;
			end
			hit_queue.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < AXES)
					box_lo[cfg_index] = cfg_data;
				else if (cfg_index < 2 * AXES)
					box_hi[cfg_index - AXES] = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (hit_queue.size() == 0) begin
					$display("%0t: result with no ray outstanding", $time);
					errors++;
				end else begin
					want = hit_queue.pop_front();
					if (out_data.hit !== want.hit)
						report("hit", want.hit, out_data.hit);
					if (out_data.t_enter !== want.t_enter)
						report("t_enter", want.t_enter, out_data.t_enter);
					if (out_data.t_exit !== want.t_exit)
						report("t_exit", want.t_exit, out_data.t_exit);
				end
			end
			if (in_valid && !in_stall)
				hit_queue.push_back(slab_test(in_data));
			pending = hit_queue.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives box corners and ray streams into the slab intersection block with
// random gaps and output stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
	import rbs_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;
	localparam value_t ONE = 32'sh0001_0000;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASES = 8;
	localparam int RAYS_PER_PHASE = 242;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	ray_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	ray_out_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	value_t cfg_data = '0;
	int errors;
	int pending;
	bit hold_req = 0;
	bit hold_done = 0;
	value_t lo [AXES];
	value_t hi [AXES];

	always #10 clk = ~clk;

	ray_box_slab_intersect DUT (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
		.out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	slab_checker u_checker (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
		.out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
	);

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, value_t val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_box();
		for (int a = 0; a < AXES; a++) begin
			write_reg(cfg_reg_t'(REG_BOX_MIN_X + a), lo[a]);
			write_reg(cfg_reg_t'(REG_BOX_MAX_X + a), hi[a]);
		end
		write_reg(REG_SPARE_6, $urandom);
		write_reg(REG_SPARE_7, $urandom);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_ray(ray_in_t ray);
		int g;
		in_valid <= 1;
		in_data  <= ray;
		do @(posedge clk); while (in_stall);
		g = $urandom_range(0, 99);
		if (g >= 70) begin
			in_valid <= 0;
			repeat (g < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
		end
	endtask

	// hold off input until every result is back, then let the pipe empty
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic value_t pick_coord(value_t l, value_t h);
		longint span;
		case ($urandom_range(0, 9))
			0: return VALUE_MIN;
			1: return VALUE_MAX;
			2, 3: return $urandom;
			default: begin
				span = longint'(h) - longint'(l);
				if (span <= 0)
					return l;
				return value_t'(longint'(l) - 4 + longint'($urandom) % (span + 9));
			end
		endcase
	endfunction

	function automatic ray_in_t rand_ray();
		ray_in_t r;
		value_t o [AXES];
		value_t d [AXES];
		longint mid;
		bit aim;
		aim = $urandom_range(0, 3) != 0;
		for (int a = 0; a < AXES; a++) begin
			o[a] = pick_coord(lo[a], hi[a]);
			mid = (longint'(lo[a]) + longint'(hi[a])) / 2;
			case ($urandom_range(0, 9))
				0: d[a] = 0;
				1: d[a] = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
				2: d[a] = $urandom;
				default:
					if (aim)
						d[a] = value_t'((mid - longint'(o[a])) >>> $urandom_range(0, 14));
					else
						d[a] = int'($urandom_range(0, 1 << 20)) - (1 << 19);
			endcase
		end
		r.origin_x = o[0]; r.origin_y = o[1]; r.origin_z = o[2];
		r.dir_x = d[0]; r.dir_y = d[1]; r.dir_z = d[2];
		case ($urandom_range(0, 5))
			0: begin r.t_start = $urandom; r.t_end = $urandom; end
			1: begin r.t_start = VALUE_MIN; r.t_end = VALUE_MAX; end
			default: begin
				r.t_start = 0;
				r.t_end = $urandom_range(0, 1) ? VALUE_MAX : value_t'($urandom_range(0, 1 << 22));
			end
		endcase
		return r;
	endfunction

	function automatic ray_in_t mk(value_t ox, value_t oy, value_t oz, value_t dx, value_t dy,
			value_t dz, value_t ts, value_t te);
		ray_in_t r;
		r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
		r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
		r.t_start = ts; r.t_end = te;
		return r;
	endfunction

	task automatic set_box(int p);
		longint c, e;
		for (int a = 0; a < AXES; a++) begin
			case (p)
				0: begin lo[a] = VALUE_MIN; hi[a] = VALUE_MAX; end
				1: begin lo[a] = $urandom; hi[a] = $urandom; end
				2: begin lo[a] = VALUE_MAX; hi[a] = VALUE_MIN; end
				3: begin lo[a] = 0; hi[a] = 0; end
				default: begin
					c = int'($urandom_range(0, 1 << 24)) - (1 << 23);
					e = $urandom_range(0, 1 << 21);
					lo[a] = value_t'(c - e);
					hi[a] = value_t'(c + e);
				end
			endcase
		end
	endtask

	initial begin
		value_t two;
		two = 2 * ONE;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int a = 0; a < AXES; a++) begin
			lo[a] = -two;
			hi[a] = two;
		end
		load_box();
		send_ray(mk(-4 * ONE, 0, 0, ONE, 0, 0, 0, VALUE_MAX));
		send_ray(mk(4 * ONE, ONE, -ONE, -ONE, 0, 0, 0, VALUE_MAX));
		// zero direction on the slab boundary, then just outside it
		send_ray(mk(0, two, -two, ONE, 0, 0, VALUE_MIN, VALUE_MAX));
		send_ray(mk(0, two + 1, 0, ONE, 0, 0, VALUE_MIN, VALUE_MAX));
		send_ray(mk(0, 0, 0, 0, 0, 0, VALUE_MIN, VALUE_MAX));
		// inverted interval with an axis that sets no limit
		send_ray(mk(0, 0, 0, 0, ONE, ONE, ONE, -ONE));
		// saturating quotients
		send_ray(mk(VALUE_MIN, 0, 0, 1, 0, 0, VALUE_MIN, VALUE_MAX));
		send_ray(mk(VALUE_MAX, 0, 0, 1, 0, 0, VALUE_MIN, VALUE_MAX));
		send_ray(mk(VALUE_MAX, VALUE_MIN, 0, VALUE_MIN, VALUE_MAX, 0, VALUE_MIN, VALUE_MAX));
		// miss on the second axis, and the interval ending before the box
		send_ray(mk(-4 * ONE, 8 * ONE, 0, ONE, ONE, 0, 0, VALUE_MAX));
		send_ray(mk(-4 * ONE, 0, 0, ONE, 0, 0, 0, ONE));
		send_ray(mk(-4 * ONE, -4 * ONE, -4 * ONE, ONE, ONE, ONE, VALUE_MIN, VALUE_MAX));
		send_ray(mk(-1, -1, -1, -1, -1, -1, -1, -1));
		send_ray(mk(VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX,
			VALUE_MAX, VALUE_MAX));
		send_ray(mk(VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN,
			VALUE_MIN, VALUE_MIN));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			set_box(p);
			load_box();
			if (p == 5)
				hold_req = 1;
			for (int i = 0; i < RAYS_PER_PHASE; i++)
				send_ray(rand_ray());
			drain();
		end

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// result side stalls; one long hold-off while rays keep coming
	initial begin
		@(posedge arst_n);
		forever begin
			int r;
			r = $urandom_range(0, 99);
			if (hold_req && !hold_done) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				hold_done = 1;
			end else if (r < 70) begin
				out_stall <= 0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else if (r < 95) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_stall <= 1;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule

@@ files.f @@
rtl/rbs_pkg.sv
rtl/rbs_div.sv
rtl/rbs_lane.sv
rtl/rbs_merge.sv
rtl/ray_box_slab_intersect.sv
dv/slab_checker.sv
dv/testbench.sv
